>>> rtl/sdsq_pkg.sv
// Shared types and constants for the SD card SPI-mode sequencer.
// Used by every module of the block; depends on nothing else.
`default_nettype none

package sdsq_pkg;

    localparam int BLOCK_BYTES = 512;
    localparam int FRAME_W     = $clog2(BLOCK_BYTES) + 1;
    localparam int WAKE_BYTES  = 10;
    localparam int CMD_BYTES   = 6;
    localparam int R7_BYTES    = 4;
    localparam int CRC_BYTES   = 2;

    typedef enum logic [3:0] {
        PH_IDLE,
        PH_WAKE,
        PH_LEAD,
        PH_CMDB,
        PH_POLL,
        PH_R7,
        PH_TRAIL,
        PH_TOKEN,
        PH_DATA,
        PH_CRC,
        PH_FINAL
    } phase_t;

    typedef enum logic [1:0] {
        CMD_INIT = 2'd0,
        CMD_READ = 2'd1,
        CMD_XFER = 2'd2,
        CMD_NONE = 2'd3
    } cmd_t;

    localparam logic [1:0] REG_RESP_LIMIT    = 2'd0;
    localparam logic [1:0] REG_TOKEN_LIMIT   = 2'd1;
    localparam logic [1:0] REG_ATTEMPT_LIMIT = 2'd2;

    localparam logic [2:0] ST_OK            = 3'd0;
    localparam logic [2:0] ST_NO_IDLE       = 3'd1;
    localparam logic [2:0] ST_BAD_CMD8      = 3'd2;
    localparam logic [2:0] ST_CMD55_REJECT  = 3'd3;
    localparam logic [2:0] ST_ACMD41_REJECT = 3'd4;
    localparam logic [2:0] ST_ATTEMPTS_OUT  = 3'd5;
    localparam logic [2:0] ST_READ_REJECT   = 3'd6;
    localparam logic [2:0] ST_TOKEN_TIMEOUT = 3'd7;

    localparam logic [5:0] SD_CMD0    = 6'd0;
    localparam logic [5:0] SD_CMD8    = 6'd8;
    localparam logic [5:0] SD_CMD17   = 6'd17;
    localparam logic [5:0] SD_ACMD41  = 6'd41;
    localparam logic [5:0] SD_CMD55   = 6'd55;

    localparam logic [7:0]  IDLE_BYTE   = 8'hFF;
    localparam logic [7:0]  START_TOKEN = 8'hFE;
    localparam logic [7:0]  CMD_PREFIX  = 8'h40;
    localparam logic [7:0]  CRC_CMD0    = 8'h95;
    localparam logic [7:0]  CRC_CMD8    = 8'h87;
    localparam logic [7:0]  CRC_END_BIT = 8'h01;
    localparam logic [7:0]  R1_READY    = 8'h00;
    localparam logic [7:0]  R1_IDLE     = 8'h01;
    localparam logic [7:0]  R1_ILLEGAL  = 8'h05;
    localparam logic [31:0] ARG_CMD8    = 32'h0000_01AA;
    localparam logic [31:0] ARG_HCS     = 32'h4000_0000;

    typedef struct packed {
        logic [7:0]  resp_limit;
        logic [19:0] token_limit;
        logic [15:0] attempt_limit;
    } limits_t;

    typedef struct packed {
        logic       send_request;
        logic [7:0] tx_byte;
        logic       card_select;
        logic       data_valid;
        logic [7:0] data_byte;
        logic       data_last;
        logic       done_res;
        logic [2:0] status;
        logic       high_capacity;
    } result_t;

endpackage

`default_nettype wire

>>> rtl/sdsq_cfg.sv
// Configuration registers of the sequencer: poll and attempt limits.
// Depends on sdsq_pkg; a limit written as zero acts as one.
`default_nettype none

module sdsq_cfg
    import sdsq_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        cfg_write,
    input  wire logic [1:0]  cfg_index,
    input  wire logic [19:0] cfg_data,
    output limits_t          limits
);

    logic [7:0]  resp_limit_reg;
    logic [19:0] token_limit_reg;
    logic [15:0] attempt_limit_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            resp_limit_reg    <= 8'd10;
            token_limit_reg   <= 20'd100000;
            attempt_limit_reg <= 16'd1000;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                REG_RESP_LIMIT:    resp_limit_reg    <= cfg_data[7:0];
                REG_TOKEN_LIMIT:   token_limit_reg   <= cfg_data;
                REG_ATTEMPT_LIMIT: attempt_limit_reg <= cfg_data[15:0];
                default:           ;
            endcase
        end
    end

    always_comb
    begin
        limits.resp_limit    = (resp_limit_reg == 8'd0) ? 8'd1 : resp_limit_reg;
        limits.token_limit   = (token_limit_reg == 20'd0) ? 20'd1 : token_limit_reg;
        limits.attempt_limit = (attempt_limit_reg == 16'd0) ? 16'd1 : attempt_limit_reg;
    end

endmodule

`default_nettype wire

>>> rtl/sdsq_core.sv
// Sequencer state and the next-state logic for one transaction.
// Depends on sdsq_pkg; state advances only when step is high.
`default_nettype none

module sdsq_core
    import sdsq_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        step,
    input  wire logic [1:0]  cmd,
    input  wire logic [31:0] block_address,
    input  wire logic [7:0]  rx_byte,
    input  wire limits_t     limits,
    output result_t          result
);

    phase_t              phase_reg,    phase_next;
    logic [FRAME_W-1:0]  frame_reg,    frame_next;
    logic [19:0]         poll_reg,     poll_next;
    logic [15:0]         attempt_reg,  attempt_next;
    logic [31:0]         arg_reg,      arg_next;
    logic [5:0]          command_reg,  command_next;
    logic                capacity_reg, capacity_next;
    logic [7:0]          response_reg, response_next;

    function automatic logic [7:0] command_byte(
        input logic [FRAME_W-1:0] idx,
        input logic [5:0]         code,
        input logic [31:0]        arg
    );
        logic [7:0] crc;
        crc = 8'h00;
        if (code == SD_CMD0)
            crc = CRC_CMD0;
        else if (code == SD_CMD8)
            crc = CRC_CMD8;
        unique case (idx)
            FRAME_W'(0): command_byte = CMD_PREFIX | {2'b00, code};
            FRAME_W'(1): command_byte = arg[31:24];
            FRAME_W'(2): command_byte = arg[23:16];
            FRAME_W'(3): command_byte = arg[15:8];
            FRAME_W'(4): command_byte = arg[7:0];
            default:     command_byte = crc | CRC_END_BIT;
        endcase
    endfunction

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg    <= PH_IDLE;
            frame_reg    <= '0;
            poll_reg     <= '0;
            attempt_reg  <= '0;
            arg_reg      <= '0;
            command_reg  <= '0;
            capacity_reg <= 1'b0;
            response_reg <= '0;
        end
        else if (step)
        begin
            phase_reg    <= phase_next;
            frame_reg    <= frame_next;
            poll_reg     <= poll_next;
            attempt_reg  <= attempt_next;
            arg_reg      <= arg_next;
            command_reg  <= command_next;
            capacity_reg <= capacity_next;
            response_reg <= response_next;
        end
    end

    always_comb
    begin
        logic [FRAME_W-1:0] frame_inc;
        logic [19:0]        poll_inc;
        logic [15:0]        attempt_inc;
        logic [7:0]         resp;
        logic               got_resp;

        frame_inc   = frame_reg + FRAME_W'(1);
        poll_inc    = poll_reg + 20'd1;
        attempt_inc = attempt_reg + 16'd1;
        resp        = rx_byte;
        got_resp    = 1'b0;

        phase_next    = phase_reg;
        frame_next    = frame_reg;
        poll_next     = poll_reg;
        attempt_next  = attempt_reg;
        arg_next      = arg_reg;
        command_next  = command_reg;
        capacity_next = capacity_reg;
        response_next = response_reg;
        result        = '0;

        unique case (cmd)
            CMD_INIT:
            begin
                capacity_next        = 1'b0;
                attempt_next         = '0;
                poll_next            = '0;
                frame_next           = '0;
                phase_next           = PH_WAKE;
                result.send_request  = 1'b1;
                result.tx_byte       = IDLE_BYTE;
            end
            CMD_READ:
            begin
                poll_next            = '0;
                frame_next           = '0;
                command_next         = SD_CMD17;
                arg_next             = block_address;
                phase_next           = PH_LEAD;
                result.send_request  = 1'b1;
                result.tx_byte       = IDLE_BYTE;
                result.card_select   = 1'b1;
            end
            CMD_XFER:
            begin
                unique case (phase_reg)
                    PH_WAKE:
                    begin
                        frame_next          = frame_inc;
                        result.send_request = 1'b1;
                        result.tx_byte      = IDLE_BYTE;
                        if (frame_inc >= FRAME_W'(WAKE_BYTES))
                        begin
                            command_next       = SD_CMD0;
                            arg_next           = '0;
                            phase_next         = PH_LEAD;
                            result.card_select = 1'b1;
                        end
                    end
                    PH_LEAD:
                    begin
                        phase_next          = PH_CMDB;
                        frame_next          = '0;
                        result.send_request = 1'b1;
                        result.card_select  = 1'b1;
                        result.tx_byte      = command_byte('0, command_reg, arg_reg);
                    end
                    PH_CMDB:
                    begin
                        frame_next          = frame_inc;
                        result.send_request = 1'b1;
                        result.card_select  = 1'b1;
                        if (frame_inc < FRAME_W'(CMD_BYTES))
                        begin
                            result.tx_byte = command_byte(frame_inc, command_reg, arg_reg);
                        end
                        else
                        begin
                            phase_next     = PH_POLL;
                            poll_next      = '0;
                            result.tx_byte = IDLE_BYTE;
                        end
                    end
                    PH_POLL:
                    begin
                        if (!rx_byte[7])
                        begin
                            got_resp = 1'b1;
                        end
                        else
                        begin
                            poll_next = poll_inc;
                            if (poll_inc >= {12'd0, limits.resp_limit})
                            begin
                                got_resp = 1'b1;
                                resp     = IDLE_BYTE;
                            end
                            else
                            begin
                                result.send_request = 1'b1;
                                result.tx_byte      = IDLE_BYTE;
                                result.card_select  = 1'b1;
                            end
                        end
                        if (got_resp)
                        begin
                            response_next       = resp;
                            result.send_request = 1'b1;
                            result.tx_byte      = IDLE_BYTE;
                            if (command_reg == SD_CMD8 && resp == R1_IDLE)
                            begin
                                phase_next         = PH_R7;
                                frame_next         = '0;
                                result.card_select = 1'b1;
                            end
                            else
                            begin
                                phase_next = PH_TRAIL;
                            end
                        end
                    end
                    PH_R7:
                    begin
                        frame_next          = frame_inc;
                        result.send_request = 1'b1;
                        result.tx_byte      = IDLE_BYTE;
                        if (frame_inc < FRAME_W'(R7_BYTES))
                            result.card_select = 1'b1;
                        else
                            phase_next = PH_TRAIL;
                    end
                    PH_TRAIL:
                    begin
                        result.tx_byte      = IDLE_BYTE;
                        result.send_request = 1'b1;
                        result.card_select  = 1'b1;
                        phase_next          = PH_LEAD;
                        unique case (command_reg)
                            SD_CMD0:
                            begin
                                if (response_reg == R1_IDLE)
                                begin
                                    command_next = SD_CMD8;
                                    arg_next     = ARG_CMD8;
                                end
                                else
                                begin
                                    result        = '0;
                                    phase_next    = PH_IDLE;
                                    result.done_res = 1'b1;
                                    result.status   = ST_NO_IDLE;
                                end
                            end
                            SD_CMD8:
                            begin
                                if (response_reg == R1_IDLE)
                                    capacity_next = 1'b1;
                                if (response_reg == R1_IDLE || response_reg == R1_ILLEGAL)
                                begin
                                    attempt_next = '0;
                                    command_next = SD_CMD55;
                                    arg_next     = '0;
                                end
                                else
                                begin
                                    result          = '0;
                                    phase_next      = PH_IDLE;
                                    result.done_res = 1'b1;
                                    result.status   = ST_BAD_CMD8;
                                end
                            end
                            SD_CMD55:
                            begin
                                if (response_reg > R1_IDLE)
                                begin
                                    result          = '0;
                                    phase_next      = PH_IDLE;
                                    result.done_res = 1'b1;
                                    result.status   = ST_CMD55_REJECT;
                                end
                                else
                                begin
                                    command_next = SD_ACMD41;
                                    arg_next     = capacity_reg ? ARG_HCS : 32'd0;
                                end
                            end
                            SD_ACMD41:
                            begin
                                if (response_reg == R1_READY)
                                begin
                                    result          = '0;
                                    phase_next      = PH_IDLE;
                                    result.done_res = 1'b1;
                                    result.status   = ST_OK;
                                end
                                else if (response_reg != R1_IDLE)
                                begin
                                    result          = '0;
                                    phase_next      = PH_IDLE;
                                    result.done_res = 1'b1;
                                    result.status   = ST_ACMD41_REJECT;
                                end
                                else
                                begin
                                    attempt_next = attempt_inc;
                                    if (attempt_inc >= limits.attempt_limit)
                                    begin
                                        result          = '0;
                                        phase_next      = PH_IDLE;
                                        result.done_res = 1'b1;
                                        result.status   = ST_ATTEMPTS_OUT;
                                    end
                                    else
                                    begin
                                        command_next = SD_CMD55;
                                        arg_next     = '0;
                                    end
                                end
                            end
                            SD_CMD17:
                            begin
                                if (response_reg != R1_READY)
                                begin
                                    result          = '0;
                                    phase_next      = PH_IDLE;
                                    result.done_res = 1'b1;
                                    result.status   = ST_READ_REJECT;
                                end
                                else
                                begin
                                    phase_next = PH_TOKEN;
                                    poll_next  = '0;
                                end
                            end
                            default:
                            begin
                                result          = '0;
                                phase_next      = PH_IDLE;
                                result.done_res = 1'b1;
                                result.status   = ST_OK;
                            end
                        endcase
                    end
                    PH_TOKEN:
                    begin
                        if (rx_byte == START_TOKEN)
                        begin
                            phase_next          = PH_DATA;
                            frame_next          = '0;
                            result.send_request = 1'b1;
                            result.tx_byte      = IDLE_BYTE;
                            result.card_select  = 1'b1;
                        end
                        else
                        begin
                            poll_next = poll_inc;
                            if (poll_inc >= limits.token_limit)
                            begin
                                phase_next      = PH_IDLE;
                                result.done_res = 1'b1;
                                result.status   = ST_TOKEN_TIMEOUT;
                            end
                            else
                            begin
                                result.send_request = 1'b1;
                                result.tx_byte      = IDLE_BYTE;
                                result.card_select  = 1'b1;
                            end
                        end
                    end
                    PH_DATA:
                    begin
                        result.data_valid   = 1'b1;
                        result.data_byte    = rx_byte;
                        result.data_last    = (frame_reg == FRAME_W'(BLOCK_BYTES - 1));
                        result.send_request = 1'b1;
                        result.tx_byte      = IDLE_BYTE;
                        result.card_select  = 1'b1;
                        if (frame_inc >= FRAME_W'(BLOCK_BYTES))
                        begin
                            phase_next = PH_CRC;
                            frame_next = '0;
                        end
                        else
                        begin
                            frame_next = frame_inc;
                        end
                    end
                    PH_CRC:
                    begin
                        frame_next          = frame_inc;
                        result.send_request = 1'b1;
                        result.tx_byte      = IDLE_BYTE;
                        if (frame_inc < FRAME_W'(CRC_BYTES))
                            result.card_select = 1'b1;
                        else
                            phase_next = PH_FINAL;
                    end
                    PH_FINAL:
                    begin
                        phase_next      = PH_IDLE;
                        result.done_res = 1'b1;
                        result.status   = ST_OK;
                    end
                    default:
                    begin
                        phase_next = PH_IDLE;
                    end
                endcase
            end
            default:
            begin
            end
        endcase

        result.high_capacity = capacity_next;
    end

endmodule

`default_nettype wire

>>> rtl/sd_spi_card_sequencer.sv
// Top level of the SD card SPI-mode sequencer: input register, result register
// and handshake control. Depends on sdsq_pkg, sdsq_cfg and sdsq_core.
//
//  Channel   Direction  Contents (lowest bit first)
//  s_axis    in         tuser: cmd[1:0]; tdata: block_address[31:0], rx_byte[39:32]
//  m_axis    out        tuser: data_valid; tlast: data_last; tdata: see port comment
//  cfg       in         cfg_write, cfg_index, cfg_data; one register per write
//
// Every transaction gives exactly one result transaction. The block takes one
// transaction per cycle while m_axis is not stalled: the input register feeds the
// sequencer logic, whose result is registered in the result register and offered
// on m_axis. The input register stalls only while a result waits on m_axis_tready.
// Reset clears the sequencer to idle and loads the default poll and attempt limits.
`default_nettype none

module sd_spi_card_sequencer
    import sdsq_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_axis_tvalid,
    output      logic        s_axis_tready,
    input  wire logic [39:0] s_axis_tdata,   // block_address, rx_byte
    input  wire logic [1:0]  s_axis_tuser,   // cmd
    output      logic        m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output      logic [23:0] m_axis_tdata,   // send_request, tx_byte, card_select,
                                             // data_byte, done_res, status,
                                             // high_capacity, zero pad
    output      logic        m_axis_tuser,   // data_valid
    output      logic        m_axis_tlast,   // data_last
    input  wire logic        cfg_write,
    input  wire logic [1:0]  cfg_index,
    input  wire logic [19:0] cfg_data
);

    logic        in_valid_reg, in_valid_next;
    logic [1:0]  in_cmd_reg;
    logic [31:0] in_addr_reg;
    logic [7:0]  in_rx_reg;
    logic        out_valid_reg, out_valid_next;
    result_t     out_result_reg;
    result_t     core_result;
    limits_t     limits;
    logic        out_free;
    logic        step;
    logic        in_fire;

    sdsq_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .limits    (limits)
    );

    sdsq_core u_core (
        .clk           (clk),
        .rst_n         (rst_n),
        .step          (step),
        .cmd           (in_cmd_reg),
        .block_address (in_addr_reg),
        .rx_byte       (in_rx_reg),
        .limits        (limits),
        .result        (core_result)
    );

    always_comb
    begin
        out_free      = !out_valid_reg || m_axis_tready;
        step          = in_valid_reg && out_free;
        s_axis_tready = !in_valid_reg || out_free;
        in_fire       = s_axis_tvalid && s_axis_tready;

        in_valid_next = in_valid_reg;
        if (in_fire)
            in_valid_next = 1'b1;
        else if (step)
            in_valid_next = 1'b0;

        out_valid_next = out_valid_reg;
        if (step)
            out_valid_next = 1'b1;
        else if (m_axis_tready)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            in_cmd_reg  <= s_axis_tuser;
            in_addr_reg <= s_axis_tdata[31:0];
            in_rx_reg   <= s_axis_tdata[39:32];
        end
        if (step)
        begin
            out_result_reg <= core_result;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tuser  = out_result_reg.data_valid;
    assign m_axis_tlast  = out_result_reg.data_last;
    assign m_axis_tdata  = {1'b0,
                            out_result_reg.high_capacity,
                            out_result_reg.status,
                            out_result_reg.done_res,
                            out_result_reg.data_byte,
                            out_result_reg.card_select,
                            out_result_reg.tx_byte,
                            out_result_reg.send_request};

endmodule

`default_nettype wire
